// ----- design/i2c_master_write_engine_defines.svh -----
// Assertion macros shared by the write engine.
`ifndef I2C_MASTER_WRITE_ENGINE_DEFINES_SVH
`define I2C_MASTER_WRITE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define I2CMW_ASSERT_IMP(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define I2CMW_ASSERT_NXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/i2cmw_pkg.sv -----
package i2cmw_pkg;

  // Function codes of an input request.
  localparam logic [1:0] FUNC_BEGIN = 2'd1;
  localparam logic [1:0] FUNC_BYTE  = 2'd2;

  // Status codes of a transaction.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SDA_LOW  = 3'd1;
  localparam logic [2:0] ST_SCL_LOW  = 3'd2;
  localparam logic [2:0] ST_ADDR_NAK = 3'd3;
  localparam logic [2:0] ST_DATA_NAK = 3'd4;

  // Largest byte count the count field can hold.
  localparam int unsigned COUNT_FIELD_MAX = 255;

  // Request class decided by the front end.
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_BEGIN = 2'd1,
    KIND_BYTE  = 2'd2
  } kind_t;

  // Bus sequencer states.
  typedef enum logic [10:0] {
    M_IDLE   = 11'b000_0000_0001,
    M_CHECK  = 11'b000_0000_0010,
    M_SEND_A = 11'b000_0000_0100,
    M_SEND_D = 11'b000_0000_1000,
    M_ACK_A  = 11'b000_0001_0000,
    M_ACK_D  = 11'b000_0010_0000,
    M_SAMP_A = 11'b000_0100_0000,
    M_SAMP_D = 11'b000_1000_0000,
    M_WAIT   = 11'b001_0000_0000,
    M_STOP2  = 11'b010_0000_0000,
    M_STOP3  = 11'b100_0000_0000
  } mode_t;

  // One classified request as held in the queue.
  typedef struct packed {
    kind_t      kind;
    logic [6:0] addr;
    logic [7:0] data;
    logic [7:0] count;
    logic       sda;
    logic       scl;
  } item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_t;

endpackage

// ----- design/i2cmw_in_if.sv -----
interface i2cmw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [6:0] addr;
  logic [7:0] data;
  logic [7:0] byte_count;
  logic       sda_in;
  logic       scl_in;

  modport source (
    output valid, func, addr, data, byte_count, sda_in, scl_in,
    input  ready
  );
  modport sink (
    input  valid, func, addr, data, byte_count, sda_in, scl_in,
    output ready
  );
endinterface

// ----- design/i2cmw_out_if.sv -----
interface i2cmw_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       need_byte;
  logic       busy_res;
  logic       done_res;
  logic [2:0] status;

  modport source (
    output valid, scl_out, sda_out, need_byte, busy_res, done_res, status,
    input  ready
  );
  modport sink (
    input  valid, scl_out, sda_out, need_byte, busy_res, done_res, status,
    output ready
  );
endinterface

// ----- design/i2cmw_front.sv -----
module i2cmw_front #(
  parameter int MAX_LEN = 255
) (
  input  logic            clk,
  input  logic            rst,
  i2cmw_in_if.sink        cmd,
  input  logic            pop,
  output i2cmw_pkg::q_t   head
);

  // The byte count field never exceeds its own maximum, so the cap only bites below it.
  localparam int CapInt = (MAX_LEN > int'(i2cmw_pkg::COUNT_FIELD_MAX)) ?
                          int'(i2cmw_pkg::COUNT_FIELD_MAX) : MAX_LEN;
  localparam logic [7:0] CapVal = 8'(CapInt);

  i2cmw_pkg::item_t queue [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             push;
  i2cmw_pkg::item_t item_in;

  assign cmd.ready = (fill != 2'd2);
  assign push      = cmd.valid && cmd.ready;

  // Classify the request and cap the byte count.
  always_comb begin
    item_in.addr  = cmd.addr;
    item_in.data  = cmd.data;
    item_in.sda   = cmd.sda_in;
    item_in.scl   = cmd.scl_in;
    item_in.count = (cmd.byte_count > CapVal) ? CapVal : cmd.byte_count;
    case (cmd.func)
      i2cmw_pkg::FUNC_BEGIN: item_in.kind = i2cmw_pkg::KIND_BEGIN;
      i2cmw_pkg::FUNC_BYTE:  item_in.kind = i2cmw_pkg::KIND_BYTE;
      default:               item_in.kind = i2cmw_pkg::KIND_TICK;
    endcase
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item_in;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  assign head.valid = (fill != 2'd0);
  assign head.item  = queue[rd_ptr];

endmodule

// ----- design/i2cmw_back.sv -----
module i2cmw_back (
  input  logic            clk,
  input  logic            rst,
  input  i2cmw_pkg::q_t   head,
  output logic            pop,
  i2cmw_out_if.source     res
);

  i2cmw_pkg::mode_t mode, mode_next;
  logic             half_phase, half_phase_next;
  logic [3:0]       bit_index, bit_index_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic [7:0]       bytes_left, bytes_left_next;
  logic [2:0]       result_code, result_code_next;
  logic             scl_o, sda_o, need, done;
  logic [3:0]       bit_inc;
  logic             out_valid;
  i2cmw_pkg::item_t it;

  assign it      = head.item;
  assign pop     = head.valid && (!out_valid || res.ready);
  assign bit_inc = bit_index + 4'd1;

  // One half-bit tick of the bus sequencer.
  always_comb begin
    mode_next        = mode;
    half_phase_next  = half_phase;
    bit_index_next   = bit_index;
    shift_byte_next  = shift_byte;
    bytes_left_next  = bytes_left;
    result_code_next = result_code;
    scl_o = 1'b1;
    sda_o = 1'b1;
    need  = 1'b0;
    done  = 1'b0;
    case (mode)
      i2cmw_pkg::M_CHECK: begin
        if (!it.sda) begin
          result_code_next = i2cmw_pkg::ST_SDA_LOW;
          done      = 1'b1;
          mode_next = i2cmw_pkg::M_IDLE;
        end else if (!it.scl) begin
          result_code_next = i2cmw_pkg::ST_SCL_LOW;
          done      = 1'b1;
          mode_next = i2cmw_pkg::M_IDLE;
        end else begin
          sda_o           = 1'b0;
          mode_next       = i2cmw_pkg::M_SEND_A;
          half_phase_next = 1'b0;
          bit_index_next  = 4'd0;
        end
      end
      i2cmw_pkg::M_SEND_A, i2cmw_pkg::M_SEND_D: begin
        sda_o = shift_byte[7];
        if (!half_phase) begin
          scl_o           = 1'b0;
          half_phase_next = 1'b1;
        end else begin
          shift_byte_next = {shift_byte[6:0], 1'b0};
          bit_index_next  = bit_inc;
          half_phase_next = 1'b0;
          if (bit_inc >= 4'd8) begin
            bit_index_next = 4'd0;
            mode_next = (mode == i2cmw_pkg::M_SEND_A) ? i2cmw_pkg::M_ACK_A :
                                                        i2cmw_pkg::M_ACK_D;
          end
        end
      end
      i2cmw_pkg::M_ACK_A, i2cmw_pkg::M_ACK_D: begin
        if (!half_phase) begin
          scl_o           = 1'b0;
          half_phase_next = 1'b1;
        end else begin
          half_phase_next = 1'b0;
          mode_next = (mode == i2cmw_pkg::M_ACK_A) ? i2cmw_pkg::M_SAMP_A :
                                                     i2cmw_pkg::M_SAMP_D;
        end
      end
      i2cmw_pkg::M_SAMP_A, i2cmw_pkg::M_SAMP_D: begin
        if (it.sda) begin
          result_code_next = (mode == i2cmw_pkg::M_SAMP_A) ? i2cmw_pkg::ST_ADDR_NAK :
                                                             i2cmw_pkg::ST_DATA_NAK;
          scl_o     = 1'b0;
          sda_o     = 1'b0;
          mode_next = i2cmw_pkg::M_STOP2;
        end else if (bytes_left == 8'd0) begin
          scl_o     = 1'b0;
          sda_o     = 1'b0;
          mode_next = i2cmw_pkg::M_STOP2;
        end else begin
          need      = 1'b1;
          mode_next = i2cmw_pkg::M_WAIT;
        end
      end
      i2cmw_pkg::M_WAIT: begin
        if (it.kind == i2cmw_pkg::KIND_BYTE) begin
          // The low half of the first data bit goes out on this tick.
          shift_byte_next = it.data;
          bytes_left_next = bytes_left - 8'd1;
          bit_index_next  = 4'd0;
          scl_o           = 1'b0;
          sda_o           = it.data[7];
          half_phase_next = 1'b1;
          mode_next       = i2cmw_pkg::M_SEND_D;
        end else begin
          need = 1'b1;
        end
      end
      i2cmw_pkg::M_STOP2: begin
        sda_o     = 1'b0;
        mode_next = i2cmw_pkg::M_STOP3;
      end
      i2cmw_pkg::M_STOP3: begin
        done      = 1'b1;
        mode_next = i2cmw_pkg::M_IDLE;
      end
      default: begin
        mode_next = i2cmw_pkg::M_IDLE;
        if (it.kind == i2cmw_pkg::KIND_BEGIN) begin
          shift_byte_next  = {it.addr, 1'b0};
          bytes_left_next  = it.count;
          bit_index_next   = 4'd0;
          half_phase_next  = 1'b0;
          result_code_next = i2cmw_pkg::ST_OK;
          mode_next        = i2cmw_pkg::M_CHECK;
        end
      end
    endcase
  end

  // Sequencer state advances once per popped request.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= i2cmw_pkg::M_IDLE;
      half_phase  <= 1'b0;
      bit_index   <= 4'd0;
      shift_byte  <= 8'd0;
      bytes_left  <= 8'd0;
      result_code <= i2cmw_pkg::ST_OK;
    end else if (pop) begin
      mode        <= mode_next;
      half_phase  <= half_phase_next;
      bit_index   <= bit_index_next;
      shift_byte  <= shift_byte_next;
      bytes_left  <= bytes_left_next;
      result_code <= result_code_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      res.scl_out   <= scl_o;
      res.sda_out   <= sda_o;
      res.need_byte <= need;
      res.busy_res  <= (mode_next != i2cmw_pkg::M_IDLE);
      res.done_res  <= done;
      res.status    <= result_code_next;
    end
  end

  assign res.valid = out_valid;

endmodule

// ----- design/i2c_master_write_engine.sv -----
// An accepted request waits in a queue entry, then its result is registered in the output register.
// Throughput: one request per cycle while results are taken; the sequencer steps one half-bit tick per request.
// A two-entry queue sits between the request classifier and the sequencer.
// Reset (synchronous, active high) empties the queue, clears the output valid flag
// and returns the sequencer to idle with status zero.
`include "i2c_master_write_engine_defines.svh"

module i2c_master_write_engine #(
  parameter int MAX_LEN = 255
) (
  input logic          clk,
  input logic          rst,
  i2cmw_in_if.sink     cmd,
  i2cmw_out_if.source  res
);

  i2cmw_pkg::q_t head;
  logic          pop;

  i2cmw_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .pop  (pop),
    .head (head)
  );

  i2cmw_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .res  (res)
  );

  // A finished transaction leaves the engine idle.
  `I2CMW_ASSERT_IMP(a_done_idle, clk, rst, res.valid && res.done_res, !res.busy_res, "done while busy")

  // While waiting for a byte both lines are released.
  `I2CMW_ASSERT_IMP(a_wait_lines, clk, rst, res.valid && res.need_byte, res.busy_res && res.scl_out && res.sda_out, "bad lines while waiting")

  // A done pulse never lasts two results.
  `I2CMW_ASSERT_NXT(a_done_pulse, clk, rst, res.valid && res.ready && res.done_res, !(res.valid && res.done_res), "done held")

  // The back end only takes requests that the queue holds.
  `I2CMW_ASSERT_IMP(a_pop_valid, clk, rst, pop, head.valid, "pop from empty queue")

endmodule
